[sv/jidct_pkg.sv]
// shared constants, types and arithmetic helpers for the 8x8 inverse dct
package jidct_pkg;

  localparam int unsigned ConstBits = 13;
  localparam int unsigned Pass1Bits = 2;
  localparam int unsigned RowShift  = ConstBits - Pass1Bits;
  localparam int unsigned ColShift  = ConstBits + Pass1Bits + 3;
  localparam int unsigned DcShift   = Pass1Bits + 3;

  localparam logic [63:0] FixScale = 64'd1000000000;
  localparam logic [63:0] FixHalf  = 64'd500000000;

  // multiplier constants, rounded at ConstBits fraction bits
  localparam logic [31:0] Fix0298 = 32'(((64'd298631336 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix0390 = 32'(((64'd390180644 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix0541 = 32'(((64'd541196100 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix0765 = 32'(((64'd765366865 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix0899 = 32'(((64'd899976223 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix1175 = 32'(((64'd1175875602 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix1501 = 32'(((64'd1501321110 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix1847 = 32'(((64'd1847759065 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix1961 = 32'(((64'd1961570560 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix2053 = 32'(((64'd2053119869 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix2562 = 32'(((64'd2562915447 << ConstBits) + FixHalf) / FixScale);
  localparam logic [31:0] Fix3072 = 32'(((64'd3072711026 << ConstBits) + FixHalf) / FixScale);

  localparam logic [31:0] LevelShift = 32'd128;
  localparam logic [7:0]  PixelMax   = 8'd255;

  typedef struct packed {
    logic       coef_wr;   // store incoming coefficient
    logic [5:0] coef_addr;
    logic       fetch;     // read one element of the current line
    logic       col_pass;
    logic [2:0] line;
    logic [2:0] elem;
    logic       wr_en;     // write one result of the current line
    logic       px_rd;     // read one pixel for output
    logic [5:0] px_addr;
  } cmd_t;

  function automatic logic [31:0] descale(input logic [31:0] x, input int unsigned n);
    logic [31:0] s;
    s = x + (32'd1 << (n - 1));
    return 32'($signed(s) >>> n);
  endfunction

  function automatic logic [7:0] clamp_pixel(input logic [31:0] x);
    logic [7:0] r;
    if (x[31]) r = 8'd0;
    else if (x > 32'(PixelMax)) r = PixelMax;
    else r = x[7:0];
    return r;
  endfunction

endpackage

[sv/jidct_ctrl.sv]
// sequencer for load, row pass, column pass and pixel output
module jidct_ctrl import jidct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic last_pixel_o,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_ORD   = 3'd4;
  localparam logic [2:0] S_OWAIT = 3'd5;

  localparam logic [2:0] CalcLast = 3'd5;  // pipeline depth after last fetch

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] line_q, line_d;
  logic [2:0] elem_q, elem_d;
  logic       pass_q, pass_d;
  logic       in_acc;

  assign in_stall_o   = (state_q != S_LOAD);
  assign in_acc       = in_valid_i && (state_q == S_LOAD);
  assign out_valid_o  = (state_q == S_OWAIT);
  assign last_pixel_o = (state_q == S_OWAIT) && (cnt_q == 6'd63);

  always_comb begin
    cmd_o           = '0;
    cmd_o.coef_wr   = in_acc;
    cmd_o.coef_addr = cnt_q;
    cmd_o.fetch     = (state_q == S_FETCH);
    cmd_o.col_pass  = pass_q;
    cmd_o.line      = line_q;
    cmd_o.elem      = elem_q;
    cmd_o.wr_en     = (state_q == S_WRITE);
    cmd_o.px_rd     = (state_q == S_ORD);
    cmd_o.px_addr   = cnt_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    elem_d  = elem_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        elem_d = elem_q + 3'd1;
        if (elem_q == 3'd7) state_d = S_CALC;
      end
      S_CALC: begin
        elem_d = elem_q + 3'd1;
        if (elem_q == CalcLast) begin
          elem_d  = 3'd0;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        elem_d = elem_q + 3'd1;
        if (elem_q == 3'd7) begin
          line_d = line_q + 3'd1;
          if (line_q != 3'd7) state_d = S_FETCH;
          else if (!pass_q) begin
            pass_d  = 1'b1;
            state_d = S_FETCH;
          end else begin
            pass_d  = 1'b0;
            state_d = S_ORD;
          end
        end
      end
      S_ORD: state_d = S_OWAIT;
      S_OWAIT: begin
        if (!out_stall_i) begin
          cnt_d   = cnt_q + 6'd1;
          state_d = (cnt_q == 6'd63) ? S_LOAD : S_ORD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      line_q  <= '0;
      elem_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      line_q  <= line_d;
      elem_q  <= elem_d;
      pass_q  <= pass_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output offered while input open");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (elem_q == 3'd0 && line_q == 3'd0 && !pass_q))
    else $error("sequencer counters not cleared on load");

  a_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && elem_q == 3'd7 && line_q == 3'd7 && pass_q)
    |=> (state_q == S_ORD && cnt_q == 6'd0))
    else $error("column pass end did not start output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(cnt_q) && out_valid_o))
    else $error("output index moved while stalled");

endmodule

[sv/jidct_datapath.sv]
// coefficient, workspace and pixel memories with the pipelined butterfly
module jidct_datapath import jidct_pkg::*; (
  input  logic              clk_i,
  input  cmd_t              cmd_i,
  input  logic signed [15:0] coefficient_i,
  output logic [7:0]        pixel_o
);

  logic [15:0] coef_mem [64];
  logic [31:0] ws_mem   [64];
  logic [7:0]  pix_mem  [64];

  logic [15:0] coef_rd_q;
  logic [31:0] ws_rd_q;
  logic [7:0]  pix_rd_q;
  logic        cap_q;
  logic [2:0]  cap_idx_q;
  logic [31:0] d_q [8];
  logic [31:0] rd_val;
  logic        ac_zero;
  logic [31:0] wr_row;
  logic [7:0]  wr_col;

  logic [5:0] row_addr, col_addr;
  assign row_addr = {cmd_i.line, cmd_i.elem};
  assign col_addr = {cmd_i.elem, cmd_i.line};

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr) coef_mem[cmd_i.coef_addr] <= coefficient_i;
    if (cmd_i.fetch && !cmd_i.col_pass) coef_rd_q <= coef_mem[row_addr];
  end

  // workspace: written row-major by the row pass, read by columns
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.col_pass) ws_mem[row_addr] <= wr_row;
    if (cmd_i.fetch && cmd_i.col_pass) ws_rd_q <= ws_mem[col_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.col_pass) pix_mem[col_addr] <= wr_col;
    if (cmd_i.px_rd) pix_rd_q <= pix_mem[cmd_i.px_addr];
  end

  assign pixel_o = pix_rd_q;

  assign rd_val = cmd_i.col_pass ? ws_rd_q : {{16{coef_rd_q[15]}}, coef_rd_q};

  always_ff @(posedge clk_i) begin
    cap_q     <= cmd_i.fetch;
    cap_idx_q <= cmd_i.elem;
    if (cap_q) d_q[cap_idx_q] <= rd_val;
  end

  // stage 1: input sums
  logic [31:0] s26_q, zz1_q, zz2_q, zz3_q, zz4_q, z34_q, tmp0_q, tmp1_q;
  always_ff @(posedge clk_i) begin
    s26_q  <= d_q[2] + d_q[6];
    zz1_q  <= d_q[7] + d_q[1];
    zz2_q  <= d_q[5] + d_q[3];
    zz3_q  <= d_q[7] + d_q[3];
    zz4_q  <= d_q[5] + d_q[1];
    z34_q  <= (d_q[7] + d_q[3]) + (d_q[5] + d_q[1]);
    tmp0_q <= (d_q[0] + d_q[4]) << ConstBits;
    tmp1_q <= (d_q[0] - d_q[4]) << ConstBits;
  end

  // stage 2: products, low 32 bits kept
  logic [31:0] z1_q, mb_q, mc_q, z5_q, p0_q, p1_q, p2_q, p3_q;
  logic [31:0] s1_q, s2_q, m3_q, m4_q, t0_q, t1_q;
  always_ff @(posedge clk_i) begin
    z1_q <= s26_q * Fix0541;
    mb_q <= d_q[6] * (32'd0 - Fix1847);
    mc_q <= d_q[2] * Fix0765;
    z5_q <= z34_q * Fix1175;
    p0_q <= d_q[7] * Fix0298;
    p1_q <= d_q[5] * Fix2053;
    p2_q <= d_q[3] * Fix3072;
    p3_q <= d_q[1] * Fix1501;
    s1_q <= zz1_q * (32'd0 - Fix0899);
    s2_q <= zz2_q * (32'd0 - Fix2562);
    m3_q <= zz3_q * (32'd0 - Fix1961);
    m4_q <= zz4_q * (32'd0 - Fix0390);
    t0_q <= tmp0_q;
    t1_q <= tmp1_q;
  end

  // stage 3: partial sums
  logic [31:0] tmp2_q, tmp3_q, s3_q, s4_q;
  logic [31:0] p0b_q, p1b_q, p2b_q, p3b_q, s1b_q, s2b_q, t0b_q, t1b_q;
  always_ff @(posedge clk_i) begin
    tmp2_q <= z1_q + mb_q;
    tmp3_q <= z1_q + mc_q;
    s3_q   <= m3_q + z5_q;
    s4_q   <= m4_q + z5_q;
    p0b_q  <= p0_q;
    p1b_q  <= p1_q;
    p2b_q  <= p2_q;
    p3b_q  <= p3_q;
    s1b_q  <= s1_q;
    s2b_q  <= s2_q;
    t0b_q  <= t0_q;
    t1b_q  <= t1_q;
  end

  // stage 4: even and odd parts
  logic [31:0] t10_q, t11_q, t12_q, t13_q, o0_q, o1_q, o2_q, o3_q;
  always_ff @(posedge clk_i) begin
    t10_q <= t0b_q + tmp3_q;
    t13_q <= t0b_q - tmp3_q;
    t11_q <= t1b_q + tmp2_q;
    t12_q <= t1b_q - tmp2_q;
    o0_q  <= p0b_q + s1b_q + s3_q;
    o1_q  <= p1b_q + s2b_q + s4_q;
    o2_q  <= p2b_q + s2b_q + s3_q;
    o3_q  <= p3b_q + s1b_q + s4_q;
  end

  // stage 5: outputs of the butterfly
  logic [31:0] res_q [8];
  always_ff @(posedge clk_i) begin
    res_q[0] <= t10_q + o3_q;
    res_q[7] <= t10_q - o3_q;
    res_q[1] <= t11_q + o2_q;
    res_q[6] <= t11_q - o2_q;
    res_q[2] <= t12_q + o1_q;
    res_q[5] <= t12_q - o1_q;
    res_q[3] <= t13_q + o0_q;
    res_q[4] <= t13_q - o0_q;
  end

  // dc-only shortcut when all ac terms of the line are zero
  assign ac_zero = (d_q[1] == '0) && (d_q[2] == '0) && (d_q[3] == '0) &&
                   (d_q[4] == '0) && (d_q[5] == '0) && (d_q[6] == '0) &&
                   (d_q[7] == '0);

  always_comb begin
    if (ac_zero) begin
      wr_row = d_q[0] << Pass1Bits;
      wr_col = clamp_pixel(descale(d_q[0], DcShift) + LevelShift);
    end else begin
      wr_row = descale(res_q[cmd_i.elem], RowShift);
      wr_col = clamp_pixel(descale(res_q[cmd_i.elem], ColShift) + LevelShift);
    end
  end

endmodule

[sv/jpeg_islow_idct_8x8.sv]
// 8x8 inverse dct (slow integer, loeffler) top level
// A block takes 64 coefficients in row-major order, one per cycle while
// in_stall_o is low. After the 64th the input stalls while the row pass and
// the column pass run: each of the 16 lines takes 8 memory reads, a pass
// through the butterfly pipeline and 8 writes. The 64 pixels then leave in
// row-major order; each is first read from the registered pixel buffer and
// only then offered on pixel_o, and last_pixel_o marks the 64th. The next
// block is taken once the last pixel transaction completes.
module jpeg_islow_idct_8x8 import jidct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [15:0] coefficient_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        pixel_o,
  output logic              last_pixel_o
);

  cmd_t cmd;

  jidct_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .last_pixel_o (last_pixel_o),
    .cmd_o        (cmd)
  );

  jidct_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .coefficient_i (coefficient_i),
    .pixel_o       (pixel_o)
  );

endmodule

[verif/tb_jpeg_islow_idct_8x8.sv]
// self-checking testbench for the 8x8 slow-integer inverse dct
`timescale 1ns / 1ps
module tb_jpeg_islow_idct_8x8;
  import jidct_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic signed [15:0] coefficient_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        pixel_o;
  logic              last_pixel_o;

  jpeg_islow_idct_8x8 dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .coefficient_i,
    .out_valid_o, .out_stall_i, .pixel_o, .last_pixel_o
  );

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pixel_t;

  pixel_t      pixel_queue[$];
  logic [15:0] coef_block[64];
  int unsigned coef_fill;
  int unsigned error_count;
  int unsigned pixels_seen;
  int unsigned blocks_sent;
  int unsigned hold_off = 0;
  int unsigned rx_wait = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  bit          rx_idle_on = 1'b1;

  // fixed-point constants, recomputed here at 13 fraction bits
  function automatic logic [31:0] fix_const(input logic [63:0] nanos);
    return 32'(((nanos << 13) + 64'd500000000) / 64'd1000000000);
  endfunction

  function automatic logic [31:0] round_shift(input logic [31:0] x, input int unsigned n);
    logic [31:0] s;
    s = x + (32'd1 << (n - 1));
    return 32'($signed(s) >>> n);
  endfunction

  function automatic logic [7:0] saturate_pixel(input logic [31:0] x);
    if (x[31]) return 8'd0;
    if (x > 32'd255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic void loeffler_8(input logic [31:0] d[8], output logic [31:0] r[8]);
    logic [31:0] z1, tmp0, tmp1, tmp2, tmp3, t10, t11, t12, t13;
    logic [31:0] zz1, zz2, zz3, zz4, z5, o0, o1, o2, o3, s1, s2, s3, s4;
    z1   = (d[2] + d[6]) * fix_const(64'd541196100);
    tmp2 = z1 + d[6] * (32'd0 - fix_const(64'd1847759065));
    tmp3 = z1 + d[2] * fix_const(64'd765366865);
    tmp0 = (d[0] + d[4]) << 13;
    tmp1 = (d[0] - d[4]) << 13;
    t10 = tmp0 + tmp3; t13 = tmp0 - tmp3;
    t11 = tmp1 + tmp2; t12 = tmp1 - tmp2;
    zz1 = d[7] + d[1]; zz2 = d[5] + d[3];
    zz3 = d[7] + d[3]; zz4 = d[5] + d[1];
    z5 = (zz3 + zz4) * fix_const(64'd1175875602);
    o0 = d[7] * fix_const(64'd298631336);
    o1 = d[5] * fix_const(64'd2053119869);
    o2 = d[3] * fix_const(64'd3072711026);
    o3 = d[1] * fix_const(64'd1501321110);
    s1 = zz1 * (32'd0 - fix_const(64'd899976223));
    s2 = zz2 * (32'd0 - fix_const(64'd2562915447));
    s3 = zz3 * (32'd0 - fix_const(64'd1961570560)) + z5;
    s4 = zz4 * (32'd0 - fix_const(64'd390180644)) + z5;
    o0 += s1 + s3; o1 += s2 + s4; o2 += s2 + s3; o3 += s1 + s4;
    r[0] = t10 + o3; r[7] = t10 - o3;
    r[1] = t11 + o2; r[6] = t11 - o2;
    r[2] = t12 + o1; r[5] = t12 - o1;
    r[3] = t13 + o0; r[4] = t13 - o0;
  endfunction

  // full 2-d reconstruction of the collected block into expected pixels
  task automatic predict_block_pixels();
    logic [31:0] work[64];
    logic [31:0] d[8], r[8];
    logic [7:0]  pix[64];
    bit          dc_only;
    pixel_t      p;
    for (int row = 0; row < 8; row++) begin
      dc_only = 1'b1;
      for (int i = 0; i < 8; i++) begin
        d[i] = {{16{coef_block[row*8+i][15]}}, coef_block[row*8+i]};
        if (i > 0 && d[i] != 0) dc_only = 1'b0;
      end
      if (dc_only) begin
        for (int i = 0; i < 8; i++) work[row*8+i] = d[0] << 2;
      end else begin
        loeffler_8(d, r);
        for (int i = 0; i < 8; i++) work[row*8+i] = round_shift(r[i], 11);
      end
    end
    for (int col = 0; col < 8; col++) begin
      dc_only = 1'b1;
      for (int i = 0; i < 8; i++) begin
        d[i] = work[i*8+col];
        if (i > 0 && d[i] != 0) dc_only = 1'b0;
      end
      if (dc_only) begin
        for (int i = 0; i < 8; i++)
          pix[i*8+col] = saturate_pixel(round_shift(d[0], 5) + 32'd128);
      end else begin
        loeffler_8(d, r);
        for (int i = 0; i < 8; i++)
          pix[i*8+col] = saturate_pixel(round_shift(r[i], 18) + 32'd128);
      end
    end
    for (int k = 0; k < 64; k++) begin
      p.pixel = pix[k];
      p.last  = (k == 63);
      pixel_queue.push_back(p);
    end
  endtask

  task automatic send_coefficient(input logic [15:0] c, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coefficient_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    coef_block[coef_fill] = c;
    coef_fill++;
    if (coef_fill == 64) begin
      coef_fill = 0;
      blocks_sent++;
      predict_block_pixels();
    end
  endtask

  task automatic send_block(input logic [15:0] blk[64], input bit gaps);
    for (int k = 0; k < 64; k++) send_coefficient(blk[k], gaps);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coef(input int unsigned mode);
    case (mode)
      0: return 16'($urandom_range(0, 64) - 32);
      1: return 16'($urandom_range(0, 2048) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed_extremes();
    logic [15:0] blk[64];
    // largest dc alone
    foreach (blk[k]) blk[k] = '0;
    blk[0] = 16'h7fff;
    send_block(blk, 1'b1);
    // all-min block wraps inside the butterfly
    foreach (blk[k]) blk[k] = 16'h8000;
    send_block(blk, 1'b0);
    // alternating extremes hit every bit both ways
    foreach (blk[k]) blk[k] = k[0] ? 16'h8000 : 16'h7fff;
    send_block(blk, 1'b1);
  endtask

  task automatic test_random_blocks(input int unsigned n);
    logic [15:0] blk[64];
    int unsigned mode;
    for (int b = 0; b < n; b++) begin
      mode = $urandom_range(0, 2);
      foreach (blk[k]) begin
        // sparse blocks exercise the dc-only shortcuts
        blk[k] = ($urandom_range(0, 3) == 0 || k == 0) ? rand_coef(mode) : '0;
        if (mode == 2 && $urandom_range(0, 1)) blk[k] = rand_coef(mode);
      end
      send_block(blk, b % 3 != 1);
    end
  endtask

  task automatic test_output_backpressure();
    logic [15:0] blk[64];
    hold_req = 1'b1;
    foreach (blk[k]) blk[k] = rand_coef(1);
    send_block(blk, 1'b0);
    foreach (blk[k]) blk[k] = rand_coef(0);
    send_block(blk, 1'b0);
  endtask

  // result stall generator: one long hold-off, else, while rx_idle_on is set, a drawn wait per transaction
  always @(posedge clk_i) begin
    int unsigned draw;
    if (hold_req && !hold_taken) begin
      hold_taken  <= 1'b1;
      hold_off    <= 700;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off    <= hold_off - 1;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= rx_wait - 1;
    end else if (rx_idle_on && out_valid_o && !out_stall_i) begin
      draw = $urandom_range(0, 17);
      out_stall_i <= (draw > 0);
      rx_wait     <= (draw > 0) ? draw - 1 : 0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen <= pixels_seen + 1;
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel %0d", pixel_o);
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (pixel_o !== want.pixel) begin
          $error("pixel: expected %0d, got %0d", want.pixel, pixel_o);
          error_count++;
        end
        if (last_pixel_o !== want.last) begin
          $error("last_pixel: expected %0b, got %0b", want.last, last_pixel_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    coef_fill = 0; error_count = 0; pixels_seen = 0; blocks_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    rx_idle_on = 1'b0;
    test_random_blocks(1);
    rx_idle_on = 1'b1;
    test_output_backpressure();
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("covered %0d blocks, %0d pixels checked", blocks_sent, pixels_seen);
    if (error_count == 0 && pixel_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
